/* hdl/sst_pkg.sv */
package sst_pkg;

  localparam int POS_W    = 16;
  localparam int LINE_W   = 16;
  localparam int WLEN_W   = 5;
  localparam int KW_NUM   = 9;
  localparam int KW_MAXLEN = 18;
  localparam int MAX_RES  = 3;
  localparam int RES_CNT_W = 2;
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);

  localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};
  localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
  localparam logic [WLEN_W-1:0] WLEN_MAX = {WLEN_W{1'b1}};

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_HIGH   = 8'h80;

  typedef enum logic [4:0] {
    K_EOF, K_WORD, K_NUMBER, K_TRUE, K_FALSE, K_PLUS, K_MINUS, K_STAR, K_SLASH,
    K_LPAREN, K_RPAREN, K_LBRACE, K_RBRACE, K_ASSIGN, K_EQ, K_IF, K_ELSE,
    K_AND, K_OR, K_LT, K_LE, K_NOT, K_NE, K_WHILE, K_BREAK, K_CONTINUE,
    K_PLUS_EQ, K_MINUS_EQ, K_STAR_EQ, K_SLASH_EQ, K_BAD
  } kind_t;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_ASG, OP_NOT, OP_LT
  } oper_t;

  typedef struct packed {
    kind_t             kind;
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  stop;
    logic [LINE_W-1:0] line;
    logic              last;
  } tok_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]     count;
    tok_t [MAX_RES-1:0]       res;
  } push_t;

  localparam logic [7:0] KW_BYTES [KW_NUM][KW_MAXLEN] = '{
    '{8'hD5,8'hB3,8'hD5,8'hAB,8'hD5,8'hB7,8'hD5,8'hBF,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'hD5,8'hA5,8'hD5,8'hA9,8'hD5,8'hA5,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'hD5,8'hB8,8'hD6,8'h82,8'hD6,8'h80,8'hD5,8'hAB,
      8'hD5,8'hB7,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'hD5,8'hAF,8'hD5,8'hA5,8'hD5,8'hAD,8'hD5,8'hAE,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'hD6,8'h87,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'hD5,8'hAF,8'hD5,8'hA1,8'hD5,8'hB4,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'hD6,8'h81,8'hD5,8'hAB,8'hD5,8'hAF,8'hD5,8'hAC,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'hD5,8'hAF,8'hD5,8'hA1,8'hD5,8'hB5,8'hD5,8'hB6,
      8'hD5,8'hAB,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'hD5,8'hB7,8'hD5,8'hA1,8'hD6,8'h80,8'hD5,8'hB8,
      8'hD6,8'h82,8'hD5,8'hB6,8'hD5,8'hA1,8'hD5,8'hAF,8'hD5,8'hAB}
  };

  localparam logic [WLEN_W-1:0] KW_LEN [KW_NUM] = '{
    5'd8, 5'd6, 5'd10, 5'd8, 5'd2, 5'd6, 5'd8, 5'd10, 5'd18
  };

  localparam kind_t KW_KIND [KW_NUM] = '{
    K_TRUE, K_IF, K_ELSE, K_FALSE, K_AND, K_OR, K_WHILE, K_BREAK, K_CONTINUE
  };

  function automatic logic is_digit(logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return ((b >= CH_UA) && (b <= CH_UZ)) || ((b >= CH_LA) && (b <= CH_LZ)) ||
           (b >= CH_HIGH);
  endfunction

  function automatic logic is_oper(logic [7:0] b);
    return (b == CH_PLUS) || (b == CH_MINUS) || (b == CH_STAR) || (b == CH_SLASH) ||
           (b == CH_EQ) || (b == CH_BANG) || (b == CH_LT);
  endfunction

  function automatic oper_t oper_of(logic [7:0] b);
    oper_t o;
    priority case (b)
      CH_PLUS:  o = OP_ADD;
      CH_MINUS: o = OP_SUB;
      CH_STAR:  o = OP_MUL;
      CH_SLASH: o = OP_DIV;
      CH_EQ:    o = OP_ASG;
      CH_BANG:  o = OP_NOT;
      default:  o = OP_LT;
    endcase
    return o;
  endfunction

  function automatic kind_t op_single(oper_t o);
    kind_t k;
    unique case (o)
      OP_ADD:  k = K_PLUS;
      OP_SUB:  k = K_MINUS;
      OP_MUL:  k = K_STAR;
      OP_DIV:  k = K_SLASH;
      OP_ASG:  k = K_ASSIGN;
      OP_NOT:  k = K_NOT;
      OP_LT:   k = K_LT;
      default: k = K_PLUS;
    endcase
    return k;
  endfunction

  function automatic kind_t op_paired(oper_t o);
    kind_t k;
    unique case (o)
      OP_ADD:  k = K_PLUS_EQ;
      OP_SUB:  k = K_MINUS_EQ;
      OP_MUL:  k = K_STAR_EQ;
      OP_DIV:  k = K_SLASH_EQ;
      OP_ASG:  k = K_EQ;
      OP_NOT:  k = K_NE;
      OP_LT:   k = K_LE;
      default: k = K_PLUS_EQ;
    endcase
    return k;
  endfunction

  function automatic kind_t bracket_kind(logic [7:0] b);
    kind_t k;
    priority case (b)
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_LBRACE: k = K_LBRACE;
      default:   k = K_RBRACE;
    endcase
    return k;
  endfunction

  function automatic logic kw_match(int k, logic [WLEN_W-1:0] pos, logic [7:0] b);
    return (pos < KW_LEN[k]) && (KW_BYTES[k][pos] == b);
  endfunction

endpackage

/* hdl/sst_lexer.sv */
module sst_lexer (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          op,
  input  logic [7:0]    text_byte,
  output sst_pkg::push_t push
);
  import sst_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE, M_OPER, M_NUM, M_DOT, M_FRAC, M_WORD
  } mode_t;

  mode_t              mode, mode_next;
  oper_t              pend, pend_next;
  logic [POS_W-1:0]   tok_begin, tok_begin_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic [LINE_W-1:0]  line, line_next;
  logic [KW_NUM-1:0]  cand, cand_next;
  logic [WLEN_W-1:0]  wlen, wlen_next;

  kind_t              rk [MAX_RES];
  logic [POS_W-1:0]   rs [MAX_RES];
  logic [POS_W-1:0]   re [MAX_RES];
  logic [RES_CNT_W-1:0] n;

  logic [POS_W-1:0]   p_inc, p_dot, tb;
  logic [KW_NUM-1:0]  feed_cand, start_cand;
  kind_t              wk;
  logic               flush, idle;

  always_comb begin
    p_inc = (pos == POS_MAX) ? pos : pos + 1'b1;
    p_dot = ((pos == '0) || (pos == POS_MAX)) ? pos : pos - 1'b1;
    for (int k = 0; k < KW_NUM; k++) begin
      feed_cand[k]  = cand[k] && kw_match(k, wlen, text_byte);
      start_cand[k] = kw_match(k, '0, text_byte);
    end
    wk = K_WORD;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      if (cand[k] && (KW_LEN[k] == wlen)) begin
        wk = KW_KIND[k];
      end
    end
  end

  always_comb begin
    mode_next      = mode;
    pend_next      = pend;
    tok_begin_next = tok_begin;
    pos_next       = pos;
    line_next      = line;
    cand_next      = cand;
    wlen_next      = wlen;
    n              = '0;
    flush          = 1'b0;
    idle           = 1'b0;
    tb             = tok_begin;
    for (int i = 0; i < MAX_RES; i++) begin
      rk[i] = K_EOF;
      rs[i] = '0;
      re[i] = '0;
    end

    if (op) begin
      flush = 1'b1;
    end else begin
      unique case (mode)
        M_WORD: begin
          if (is_letter(text_byte) || is_digit(text_byte)) begin
            cand_next = feed_cand;
            wlen_next = (wlen == WLEN_MAX) ? wlen : wlen + 1'b1;
          end else begin
            flush = 1'b1;
            idle  = 1'b1;
          end
        end
        M_NUM: begin
          if (is_digit(text_byte)) begin
            mode_next = M_NUM;
          end else if (text_byte == CH_DOT) begin
            mode_next = M_DOT;
          end else begin
            flush = 1'b1;
            idle  = 1'b1;
          end
        end
        M_DOT: begin
          if (is_digit(text_byte)) begin
            mode_next = M_FRAC;
          end else begin
            flush = 1'b1;
            idle  = 1'b1;
          end
        end
        M_FRAC: begin
          if (!is_digit(text_byte)) begin
            flush = 1'b1;
            idle  = 1'b1;
          end
        end
        M_OPER: begin
          if (text_byte == CH_EQ) begin
            rk[n] = op_paired(pend);
            rs[n] = tok_begin;
            re[n] = p_inc;
            n = n + 1'b1;
            mode_next = M_IDLE;
          end else begin
            flush = 1'b1;
            idle  = 1'b1;
          end
        end
        default: begin
          idle = 1'b1;
        end
      endcase
    end

    if (flush) begin
      unique case (mode)
        M_WORD: begin
          rk[n] = wk;
          rs[n] = tb;
          re[n] = pos;
          n = n + 1'b1;
        end
        M_NUM, M_FRAC: begin
          rk[n] = K_NUMBER;
          rs[n] = tb;
          re[n] = pos;
          n = n + 1'b1;
        end
        M_DOT: begin
          rk[n] = K_NUMBER;
          rs[n] = tb;
          re[n] = p_dot;
          n = n + 1'b1;
          tb = p_dot;
          rk[n] = K_BAD;
          rs[n] = p_dot;
          re[n] = pos;
          n = n + 1'b1;
        end
        M_OPER: begin
          rk[n] = op_single(pend);
          rs[n] = tb;
          re[n] = pos;
          n = n + 1'b1;
        end
        default: begin
          mode_next = M_IDLE;
        end
      endcase
      mode_next      = M_IDLE;
      tok_begin_next = tb;
    end

    if (op) begin
      rk[n] = K_EOF;
      rs[n] = tb;
      re[n] = pos;
      n = n + 1'b1;
      mode_next      = M_IDLE;
      pend_next      = OP_ADD;
      tok_begin_next = '0;
      pos_next       = '0;
      line_next      = LINE_W'(1);
      cand_next      = '1;
      wlen_next      = '0;
    end else begin
      pos_next = p_inc;
    end

    if (idle) begin
      mode_next = M_IDLE;
      if (text_byte == CH_NL) begin
        line_next = (line == LINE_MAX) ? line : line + 1'b1;
      end else if ((text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
                   (text_byte == CH_CR)) begin
        mode_next = M_IDLE;
      end else if (is_oper(text_byte)) begin
        mode_next      = M_OPER;
        pend_next      = oper_of(text_byte);
        tok_begin_next = pos;
      end else if ((text_byte == CH_LPAREN) || (text_byte == CH_RPAREN) ||
                   (text_byte == CH_LBRACE) || (text_byte == CH_RBRACE)) begin
        tok_begin_next = pos;
        rk[n] = bracket_kind(text_byte);
        rs[n] = pos;
        re[n] = p_inc;
        n = n + 1'b1;
      end else if (is_digit(text_byte)) begin
        mode_next      = M_NUM;
        tok_begin_next = pos;
      end else if (is_letter(text_byte) || (text_byte == CH_UNDER)) begin
        mode_next      = M_WORD;
        tok_begin_next = pos;
        cand_next      = start_cand;
        wlen_next      = WLEN_W'(1);
      end else begin
        tok_begin_next = pos;
        rk[n] = K_BAD;
        rs[n] = pos;
        re[n] = p_inc;
        n = n + 1'b1;
      end
    end
  end

  always_comb begin
    push.count = accept ? n : '0;
    for (int i = 0; i < MAX_RES; i++) begin
      push.res[i].kind  = rk[i];
      push.res[i].start = rs[i];
      push.res[i].stop  = re[i];
      push.res[i].line  = line;
      push.res[i].last  = (n == RES_CNT_W'(i + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      pend      <= OP_ADD;
      tok_begin <= '0;
      pos       <= '0;
      line      <= LINE_W'(1);
      cand      <= '1;
      wlen      <= '0;
    end else if (accept) begin
      mode      <= mode_next;
      pend      <= pend_next;
      tok_begin <= tok_begin_next;
      pos       <= pos_next;
      line      <= line_next;
      cand      <= cand_next;
      wlen      <= wlen_next;
    end
  end

endmodule

/* hdl/sst_out_queue.sv */
module sst_out_queue (
  input  logic          clk,
  input  logic          rst,
  input  sst_pkg::push_t push,
  output logic          room,
  output logic          head_valid,
  output sst_pkg::tok_t head,
  input  logic          head_taken
);
  import sst_pkg::*;

  tok_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr, rd;
  logic [Q_PTR_W:0]   count;
  logic               pop;

  assign pop        = head_valid && head_taken;
  assign head_valid = (count != '0);
  assign head       = mem[rd];
  assign room       = (count <= (Q_PTR_W + 1)'(Q_DEPTH - MAX_RES));

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (RES_CNT_W'(i) < push.count) begin
        mem[wr + Q_PTR_W'(i)] <= push.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      wr    <= wr + Q_PTR_W'(push.count);
      rd    <= rd + Q_PTR_W'(pop);
      count <= count + (Q_PTR_W + 1)'(push.count) - (Q_PTR_W + 1)'(pop);
    end
  end

endmodule

/* hdl/source_text_tokenizer.sv */
// Channel | Handshake                 | Payload
// byte    | byte_valid / byte_ready   | op, text_byte
// token   | token_valid / token_ready | token_kind, token_start, token_end,
//         |                           | token_line, run_last
//
// One byte per cycle while byte_ready is high; a byte's tokens are registered in the output queue when it is taken.
// A byte yields up to three tokens, written together into a four-entry
// output queue; byte_ready is low while more than one token waits in it.
// Tokens leave the queue one per cycle while token_ready is high, so the output side sets the rate.
// rst (synchronous) clears the scanner state and empties the queue.
module source_text_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic        op,
  input  logic [7:0]  text_byte,
  output logic        token_valid,
  input  logic        token_ready,
  output logic [4:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_end,
  output logic [15:0] token_line,
  output logic        run_last
);
  import sst_pkg::*;

  push_t push;
  tok_t  head;
  logic  accept;

  assign accept = byte_valid && byte_ready;

  sst_lexer u_lexer (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (op),
    .text_byte (text_byte),
    .push      (push)
  );

  sst_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (byte_ready),
    .head_valid (token_valid),
    .head       (head),
    .head_taken (token_ready)
  );

  assign token_kind  = head.kind;
  assign token_start = head.start;
  assign token_end   = head.stop;
  assign token_line  = head.line;
  assign run_last    = head.last;

  a_eof_emits: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_ready && op |=> token_valid)
    else $error("end of text produced no token");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    token_valid && (token_kind == K_EOF) |-> run_last)
    else $error("eof token not marked last");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> (token_line != '0))
    else $error("token line is zero");

endmodule

/* dv/tb_source_text_tokenizer.sv */
`timescale 1ns / 100ps

module tb_source_text_tokenizer;
  import sst_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 480;
  localparam int NUM_DIRECTED = 24;
  localparam logic [15:0] OFS_MAX = 16'hFFFF;
  localparam logic [7:0] CH_GT = 8'h3E;

  localparam logic [7:0] OPER_CHARS [7] = '{
    CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQ, CH_BANG, CH_LT
  };
  localparam logic [7:0] BRACKET_CHARS [4] = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE};
  localparam logic [7:0] BLANK_CHARS [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_NL};

  typedef enum logic [2:0] {
    SC_IDLE, SC_OPER, SC_NUM, SC_DOT, SC_FRAC, SC_WORD
  } scan_t;

  typedef struct {
    logic       op;
    logic [7:0] b;
  } text_item_t;

  typedef struct {
    logic        op;
    logic [7:0]  b;
    logic        typed;
    kind_t       kind;
    logic [15:0] s;
    logic [15:0] e;
    logic [15:0] ln;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        op = 1'b0;
  logic [7:0]  text_byte = 8'h00;
  logic        token_ready = 1'b0;
  logic        byte_ready;
  logic        token_valid;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_end;
  logic [15:0] token_line;
  logic        run_last;

  source_text_tokenizer dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .op          (op),
    .text_byte   (text_byte),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_kind  (token_kind),
    .token_start (token_start),
    .token_end   (token_end),
    .token_line  (token_line),
    .run_last    (run_last)
  );

  always #4 clk = ~clk;

  scan_t       mode;
  oper_t       pend_op;
  logic [15:0] tok_begin;
  logic [15:0] byte_pos;
  logic [15:0] line_no;
  logic [8:0]  kw_mask;
  logic [4:0]  word_len;

  tok_t        step_toks[$];
  tok_t        expected_tokens[$];
  text_item_t  text_q[$];
  stim_row_t   directed_rows [NUM_DIRECTED];

  int errors = 0;
  int items_sent = 0;
  int eot_sent = 0;
  int tokens_checked = 0;
  int stall_count = 0;
  int hold_request = 0;
  int kind_hits [32];

  function automatic void clear_scanner();
    mode = SC_IDLE;
    pend_op = OP_ADD;
    tok_begin = '0;
    byte_pos = '0;
    line_no = 16'd1;
    kw_mask = '1;
    word_len = '0;
  endfunction

  function automatic logic [15:0] bump(logic [15:0] p);
    return (p == OFS_MAX) ? p : p + 16'd1;
  endfunction

  function automatic logic digit_char(logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic alpha_char(logic [7:0] b);
    return ((b >= CH_UA) && (b <= CH_UZ)) || ((b >= CH_LA) && (b <= CH_LZ)) || b[7];
  endfunction

  function automatic logic operator_char(input logic [7:0] b, output oper_t o);
    logic found;
    found = 1'b1;
    o = OP_ADD;
    case (b)
      CH_PLUS:  o = OP_ADD;
      CH_MINUS: o = OP_SUB;
      CH_STAR:  o = OP_MUL;
      CH_SLASH: o = OP_DIV;
      CH_EQ:    o = OP_ASG;
      CH_BANG:  o = OP_NOT;
      CH_LT:    o = OP_LT;
      default:  found = 1'b0;
    endcase
    return found;
  endfunction

  function automatic kind_t oper_kind(oper_t o, logic paired);
    kind_t k;
    if (paired) begin
      case (o)
        OP_ADD:  k = K_PLUS_EQ;
        OP_SUB:  k = K_MINUS_EQ;
        OP_MUL:  k = K_STAR_EQ;
        OP_DIV:  k = K_SLASH_EQ;
        OP_ASG:  k = K_EQ;
        OP_NOT:  k = K_NE;
        default: k = K_LE;
      endcase
    end else begin
      case (o)
        OP_ADD:  k = K_PLUS;
        OP_SUB:  k = K_MINUS;
        OP_MUL:  k = K_STAR;
        OP_DIV:  k = K_SLASH;
        OP_ASG:  k = K_ASSIGN;
        OP_NOT:  k = K_NOT;
        default: k = K_LT;
      endcase
    end
    return k;
  endfunction

  function automatic void add_tok(kind_t k, logic [15:0] s, logic [15:0] e);
    tok_t t;
    t.kind = k;
    t.start = s;
    t.stop = e;
    t.line = line_no;
    t.last = 1'b0;
    if (step_toks.size() < MAX_RES) step_toks.insert(step_toks.size(), t);
  endfunction

  function automatic void feed_word(logic [7:0] b);
    for (int k = 0; k < KW_NUM; k++) begin
      if (word_len >= KW_LEN[k]) kw_mask[k] = 1'b0;
      else if (KW_BYTES[k][word_len] != b) kw_mask[k] = 1'b0;
    end
    if (word_len != WLEN_MAX) word_len = word_len + 5'd1;
  endfunction

  function automatic kind_t word_kind();
    kind_t k;
    k = K_WORD;
    for (int i = KW_NUM - 1; i >= 0; i--) begin
      if (kw_mask[i] && KW_LEN[i] == word_len) k = KW_KIND[i];
    end
    return k;
  endfunction

  function automatic void start_byte(logic [7:0] b, logic [15:0] p);
    oper_t o;
    kind_t bk;
    mode = SC_IDLE;
    if (b == CH_NL) begin
      if (line_no != LINE_MAX) line_no = line_no + 16'd1;
    end else if (b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
    end else if (operator_char(b, o)) begin
      mode = SC_OPER;
      pend_op = o;
      tok_begin = p;
    end else if (b == CH_LPAREN || b == CH_RPAREN || b == CH_LBRACE || b == CH_RBRACE) begin
      case (b)
        CH_LPAREN: bk = K_LPAREN;
        CH_RPAREN: bk = K_RPAREN;
        CH_LBRACE: bk = K_LBRACE;
        default:   bk = K_RBRACE;
      endcase
      tok_begin = p;
      add_tok(bk, p, bump(p));
    end else if (digit_char(b)) begin
      mode = SC_NUM;
      tok_begin = p;
    end else if (alpha_char(b) || b == CH_UNDER) begin
      mode = SC_WORD;
      tok_begin = p;
      kw_mask = '1;
      word_len = '0;
      feed_word(b);
    end else begin
      tok_begin = p;
      add_tok(K_BAD, p, bump(p));
    end
  endfunction

  function automatic void flush_dot(logic [15:0] p);
    logic [15:0] d;
    d = (p == 16'd0 || p == OFS_MAX) ? p : p - 16'd1;
    add_tok(K_NUMBER, tok_begin, d);
    tok_begin = d;
    add_tok(K_BAD, d, p);
    mode = SC_IDLE;
  endfunction

  function automatic void flush_token(logic [15:0] p);
    case (mode)
      SC_WORD:         add_tok(word_kind(), tok_begin, p);
      SC_NUM, SC_FRAC: add_tok(K_NUMBER, tok_begin, p);
      SC_DOT:          flush_dot(p);
      SC_OPER:         add_tok(oper_kind(pend_op, 1'b0), tok_begin, p);
      default: ;
    endcase
    mode = SC_IDLE;
  endfunction

  function automatic void scan_text_byte(logic [7:0] b);
    logic [15:0] p;
    p = byte_pos;
    case (mode)
      SC_WORD: begin
        if (alpha_char(b) || digit_char(b)) feed_word(b);
        else begin
          flush_token(p);
          start_byte(b, p);
        end
      end
      SC_NUM: begin
        if (b == CH_DOT) mode = SC_DOT;
        else if (!digit_char(b)) begin
          flush_token(p);
          start_byte(b, p);
        end
      end
      SC_DOT: begin
        if (digit_char(b)) mode = SC_FRAC;
        else begin
          flush_dot(p);
          start_byte(b, p);
        end
      end
      SC_FRAC: begin
        if (!digit_char(b)) begin
          flush_token(p);
          start_byte(b, p);
        end
      end
      SC_OPER: begin
        if (b == CH_EQ) begin
          add_tok(oper_kind(pend_op, 1'b1), tok_begin, bump(p));
          mode = SC_IDLE;
        end else begin
          flush_token(p);
          start_byte(b, p);
        end
      end
      default: start_byte(b, p);
    endcase
    byte_pos = bump(p);
  endfunction

  function automatic void scan_item(logic o, logic [7:0] b);
    step_toks.delete();
    if (o) begin
      flush_token(byte_pos);
      add_tok(K_EOF, tok_begin, byte_pos);
      clear_scanner();
    end else begin
      scan_text_byte(b);
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
  endfunction

  function automatic int draw_gap(logic quiet);
    return quiet ? 0 : int'($urandom_range(0, 15));
  endfunction

  function automatic void add_text(logic o, logic [7:0] b);
    text_item_t it;
    it.op = o;
    it.b = b;
    text_q.insert(text_q.size(), it);
  endfunction

  function automatic logic [7:0] word_char(logic lead);
    logic [7:0] c;
    case ($urandom_range(0, lead ? 3 : 4))
      0:       c = 8'(CH_LA + $urandom_range(0, 25));
      1:       c = 8'(CH_UA + $urandom_range(0, 25));
      2:       c = CH_UNDER;
      3:       c = 8'($urandom_range(128, 255));
      default: c = 8'(CH_ZERO + $urandom_range(0, 9));
    endcase
    return c;
  endfunction

  function automatic void plan_fragment();
    int k;
    int n;
    int variant;
    if ($urandom_range(0, 19) == 0) add_text(1'b1, 8'($urandom_range(0, 255)));
    case ($urandom_range(0, 13))
      0, 1, 2: begin
        k = $urandom_range(0, KW_NUM - 1);
        n = KW_LEN[k];
        variant = $urandom_range(0, 3);
        if (variant == 0 && n > 1) n--;
        for (int i = 0; i < n; i++) add_text(1'b0, KW_BYTES[k][i]);
        if (variant == 1) add_text(1'b0, word_char(1'b1));
      end
      3, 4: begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
        add_text(1'b0, word_char(1'b1));
        for (int i = 1; i < n; i++) add_text(1'b0, word_char(1'b0));
      end
      5, 6: begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) add_text(1'b0, 8'(CH_ZERO + $urandom_range(0, 9)));
        variant = $urandom_range(0, 2);
        if (variant != 0) add_text(1'b0, CH_DOT);
        if (variant == 1) begin
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) add_text(1'b0, 8'(CH_ZERO + $urandom_range(0, 9)));
        end
      end
      7, 8: begin
        add_text(1'b0, OPER_CHARS[$urandom_range(0, 6)]);
        if ($urandom_range(0, 1) == 1) add_text(1'b0, CH_EQ);
      end
      9:       add_text(1'b0, BRACKET_CHARS[$urandom_range(0, 3)]);
      10, 11:  add_text(1'b0, BLANK_CHARS[$urandom_range(0, 3)]);
      default: add_text(1'b0, 8'($urandom_range(0, 255)));
    endcase
    if ($urandom_range(0, 2) == 0) add_text(1'b0, CH_SPACE);
  endfunction

  task automatic send_item(logic o, logic [7:0] b, int gap);
    @(negedge clk);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid <= 1'b1;
    op <= o;
    text_byte <= b;
    do @(posedge clk); while (!byte_ready);
  endtask

  task automatic apply_item(logic o, logic [7:0] b, int gap, logic typed, tok_t typed_tok);
    tok_t t;
    send_item(o, b, gap);
    scan_item(o, b);
    if (typed) begin
      t = typed_tok;
      t.last = 1'b1;
      step_toks.delete();
      step_toks.insert(0, t);
    end
    foreach (step_toks[i]) expected_tokens.insert(expected_tokens.size(), step_toks[i]);
    items_sent++;
    if (o) eot_sent++;
  endtask

  task automatic check_token();
    tok_t want;
    if (expected_tokens.size() == 0) begin
      $error("unexpected token: kind %0d start %0d end %0d", token_kind, token_start, token_end);
      errors++;
    end else begin
      want = expected_tokens.pop_front();
      if (token_kind !== want.kind) begin
        $error("token_kind: expected %0d, actual %0d", want.kind, token_kind);
        errors++;
      end
      if (token_start !== want.start) begin
        $error("token_start: expected %0d, actual %0d", want.start, token_start);
        errors++;
      end
      if (token_end !== want.stop) begin
        $error("token_end: expected %0d, actual %0d", want.stop, token_end);
        errors++;
      end
      if (token_line !== want.line) begin
        $error("token_line: expected %0d, actual %0d", want.line, token_line);
        errors++;
      end
      if (run_last !== want.last) begin
        $error("run_last: expected %0d, actual %0d", want.last, run_last);
        errors++;
      end
      kind_hits[token_kind]++;
      tokens_checked++;
    end
  endtask

  // hold token_ready low for the requested stretch, else draw a gap per token
  initial begin
    int gap;
    wait (rst === 1'b0);
    forever begin
      if (hold_request > 0) begin
        gap = hold_request;
        hold_request = 0;
      end else begin
        gap = draw_gap(((tokens_checked / 32) % 3) == 2);
      end
      @(negedge clk);
      if (gap > 0) begin
        token_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      token_ready <= 1'b1;
      do @(posedge clk); while (!token_valid);
      check_token();
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (token_valid && token_ready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    text_item_t it;
    tok_t       row_tok;
    int         rnd_sent;
    int         kinds_seen;

    directed_rows = '{
      '{1'b1, 8'hFF,     1'b1, K_EOF,    16'd0, 16'd0, 16'd1},
      '{1'b0, CH_LPAREN, 1'b1, K_LPAREN, 16'd0, 16'd1, 16'd1},
      '{1'b0, CH_GT,     1'b1, K_BAD,    16'd1, 16'd2, 16'd1},
      '{1'b0, 8'h00,     1'b1, K_BAD,    16'd2, 16'd3, 16'd1},
      '{1'b0, 8'hFF,     1'b0, K_EOF,    16'd0, 16'd0, 16'd0},
      '{1'b0, CH_NL,     1'b0, K_EOF,    16'd0, 16'd0, 16'd0},
      '{1'b0, 8'h37,     1'b0, K_EOF,    16'd0, 16'd0, 16'd0},
      '{1'b0, CH_DOT,    1'b0, K_EOF,    16'd0, 16'd0, 16'd0},
      '{1'b0, CH_PLUS,   1'b0, K_EOF,    16'd0, 16'd0, 16'd0},
      '{1'b0, CH_EQ,     1'b0, K_EOF,    16'd0, 16'd0, 16'd0},
      '{1'b0, CH_BANG,   1'b0, K_EOF,    16'd0, 16'd0, 16'd0},
      '{1'b1, 8'h00,     1'b0, K_EOF,    16'd0, 16'd0, 16'd0},
      '{1'b0, 8'hD6,     1'b0, K_EOF,    16'd0, 16'd0, 16'd0},
      '{1'b0, 8'h87,     1'b0, K_EOF,    16'd0, 16'd0, 16'd0},
      '{1'b0, CH_LT,     1'b0, K_EOF,    16'd0, 16'd0, 16'd0},
      '{1'b0, 8'h33,     1'b0, K_EOF,    16'd0, 16'd0, 16'd0},
      '{1'b0, CH_DOT,    1'b0, K_EOF,    16'd0, 16'd0, 16'd0},
      '{1'b0, 8'h35,     1'b0, K_EOF,    16'd0, 16'd0, 16'd0},
      '{1'b0, CH_UNDER,  1'b0, K_EOF,    16'd0, 16'd0, 16'd0},
      '{1'b0, CH_UNDER,  1'b0, K_EOF,    16'd0, 16'd0, 16'd0},
      '{1'b0, CH_RBRACE, 1'b0, K_EOF,    16'd0, 16'd0, 16'd0},
      '{1'b0, CH_NINE,   1'b0, K_EOF,    16'd0, 16'd0, 16'd0},
      '{1'b0, CH_DOT,    1'b0, K_EOF,    16'd0, 16'd0, 16'd0},
      '{1'b1, 8'h55,     1'b0, K_EOF,    16'd0, 16'd0, 16'd0}
    };
    foreach (kind_hits[i]) kind_hits[i] = 0;
    clear_scanner();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row_tok.kind = directed_rows[i].kind;
      row_tok.start = directed_rows[i].s;
      row_tok.stop = directed_rows[i].e;
      row_tok.line = directed_rows[i].ln;
      row_tok.last = 1'b1;
      apply_item(directed_rows[i].op, directed_rows[i].b, draw_gap(1'b0),
                 directed_rows[i].typed, row_tok);
    end

    rnd_sent = 0;
    while (rnd_sent < RANDOM_ITEMS) begin
      if (rnd_sent == 150) hold_request = HOLD_CYCLES;
      if (rnd_sent == 320) begin
        @(negedge clk);
        byte_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge clk);
      end
      if (text_q.size() == 0) plan_fragment();
      it = text_q.pop_front();
      apply_item(it.op, it.b, draw_gap(((items_sent / 64) % 3) == 1), 1'b0, '0);
      rnd_sent++;
    end

    @(negedge clk);
    byte_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    kinds_seen = 0;
    foreach (kind_hits[i]) if (kind_hits[i] > 0) kinds_seen++;
    $display("Run covered %0d input transactions (%0d end of text), %0d tokens checked,",
             items_sent, eot_sent, tokens_checked);
    $display("%0d distinct token kinds seen, with a long output stall and a drained pause.",
             kinds_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
